// File: rtl/stwa_pkg.sv
// Shared constants, types and sample conversion for the scope trace block.
package stwa_pkg;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 17;
  localparam int MAG_W        = 17;
  localparam int HEIGHT_W     = 10;
  localparam int ENERGY_W     = 27;
  localparam int PEAK_W       = 17;
  localparam int PACC_W       = 20;
  localparam int SQ_SHIFT     = 16;
  localparam int SQ_W         = 2 * MAG_W - SQ_SHIFT;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int DIV_STEP_W   = 5;

  // Reset values and thresholds
  localparam int HEIGHT_RESET = 128;
  localparam int PAGE_DEFAULT = 28000;
  localparam int MIN_ENERGY   = 100;

  // Default sizing
  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_AGC_PAGES   = 16;
  localparam int DEF_AGC_FRAMES  = 8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT    = 2'd0,
    CFG_STEREO    = 2'd1,
    CFG_EIGHT_BIT = 2'd2
  } cfg_idx_t;

  // Divider request: start pulse and number of quotient bits
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  // Status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Raw sample to signed 16-bit; eight-bit mode maps (byte - 128) * 256
  function automatic logic signed [SAMPLE_W-1:0] convert_sample(
    input logic [SAMPLE_W-1:0] raw,
    input logic                eight_bit
  );
    logic signed [SAMPLE_W-1:0] res;
    if (eight_bit) begin
      res = {~raw[7], raw[6:0], 8'h00};
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// File: rtl/scope_trace_with_agc.sv
// Scope trace generator with automatic gain control, top level.
// One item per display column: the sample (or stereo sum) is divided by the
// gain scale, offset to mid-height and clamped. A column is taken only while
// the sequencer is idle. The shared one-bit-per-cycle divider first forms the
// scale (amplitude over height/4) and then the quotient of the sample
// magnitude; the squarer for the energy runs alongside. The last column of a
// frame adds a mean-energy check. When a page of frames completes, it also
// adds two more divisions, for the page value and the ring average. The
// result sits in an output register. A result still waiting there holds the
// next column at its output step until the beat is taken.
module scope_trace_with_agc #(
  parameter int MAX_COLUMNS = stwa_pkg::DEF_MAX_COLUMNS,
  parameter int AGC_PAGES   = stwa_pkg::DEF_AGC_PAGES,
  parameter int AGC_FRAMES  = stwa_pkg::DEF_AGC_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: left_sample [15:0], right_sample [31:16]
  input  logic [stwa_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: trace_value [9:0], zero fill [15:10]
  output logic [stwa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [stwa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stwa_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int MAG_W    = stwa_pkg::MAG_W;
  localparam int SUM_W    = stwa_pkg::SUM_W;
  localparam int H_W      = stwa_pkg::HEIGHT_W;
  localparam int E_W      = stwa_pkg::ENERGY_W;
  localparam int PACC_W   = stwa_pkg::PACC_W;
  localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
  localparam int FR_W     = $clog2(AGC_FRAMES + 1);
  localparam int HEAD_W   = $clog2(AGC_PAGES);
  localparam int PAGE_MAX = ((1 << PACC_W) - 1) / AGC_FRAMES;
  localparam int PAGE_W   = $clog2(PAGE_MAX + 1);
  localparam int AVG_W    = PAGE_W;
  localparam int TOT_W    = PAGE_W + $clog2(AGC_PAGES);
  localparam int DIV_W    = (TOT_W > PACC_W) ? TOT_W : PACC_W;
  localparam int POS_W    = MAG_W + 2;
  localparam int SW       = stwa_pkg::DIV_STEP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_QUOT, S_OUT, S_MEAN, S_PAGE, S_AVG
  } state_t;

  // Registers
  state_t                  state_r, state_nxt;
  logic [H_W-1:0]          height_r, height_nxt;
  logic                    stereo_r, stereo_nxt;
  logic                    eight_r, eight_nxt;
  logic                    neg_r, neg_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    last_r, last_nxt;
  logic [MAG_W-1:0]        quot_r, quot_nxt;
  logic [E_W-1:0]          energy_r, energy_nxt;
  logic [stwa_pkg::PEAK_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [PACC_W-1:0]       pacc_r, pacc_nxt;
  logic [FR_W-1:0]         frames_r, frames_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic [HEAD_W-1:0]       head_r, head_nxt;
  logic [AVG_W-1:0]        avg_r, avg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [H_W-1:0]          out_trace_r, out_trace_nxt;
  logic                    out_last_r, out_last_nxt;

  // Unit connections
  stwa_pkg::div_req_t      div_req;
  logic [DIV_W-1:0]        div_dividend;
  logic [PAGE_W-1:0]       div_divisor;
  logic [DIV_W-1:0]        div_quot;
  stwa_pkg::unit_sts_t     div_sts;
  logic                    sqr_start;
  logic [2*MAG_W-1:0]      sqr_prod;
  stwa_pkg::unit_sts_t     sqr_sts;
  logic                    ring_we;
  logic [PAGE_W-1:0]       ring_wdata;
  logic [PAGE_W-1:0]       ring_rdata;

  // Combinational helpers
  logic signed [stwa_pkg::SAMPLE_W-1:0] left_c, right_c;
  logic signed [SUM_W-1:0] sum_c;
  logic [MAG_W-1:0]        mag_c;
  logic                    in_fire;
  logic [H_W-3:0]          target;
  logic [PAGE_W-1:0]       target_eff;
  logic [AVG_W-1:0]        scale_eff;
  logic signed [POS_W-1:0] qs, half_s, pos_s, upper_s;
  logic [H_W-1:0]          upper, trace_c;
  logic [E_W:0]            e_sum;
  logic [stwa_pkg::SQ_W-1:0] sq_hi;
  logic [E_W-1:0]          thresh;
  logic                    hit;
  logic [PACC_W:0]         pacc_sum;
  logic [PACC_W-1:0]       pacc_sat;
  logic [FR_W-1:0]         frames_inc;
  logic                    page_full;
  logic [PAGE_W-1:0]       page;
  logic [TOT_W:0]          total_calc;
  logic [TOT_W-1:0]        total_new;
  logic                    out_free;

  // Sample conversion and magnitude
  always_comb begin
    left_c  = stwa_pkg::convert_sample(in_tdata[15:0], eight_r);
    right_c = stwa_pkg::convert_sample(in_tdata[31:16], eight_r);
    sum_c   = {left_c[15], left_c} + (stereo_r ? {right_c[15], right_c} : SUM_W'(0));
    mag_c   = sum_c[SUM_W-1] ? MAG_W'(-sum_c) : MAG_W'(sum_c);
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Scale divisor and trace position
  always_comb begin
    target     = height_r[H_W-1:2];
    target_eff = (target == '0) ? PAGE_W'(1) : PAGE_W'(target);
    scale_eff  = (div_quot[AVG_W-1:0] == '0) ? AVG_W'(1) : div_quot[AVG_W-1:0];
    qs         = neg_r ? -$signed(POS_W'(quot_r)) : $signed(POS_W'(quot_r));
    half_s     = $signed(POS_W'(height_r[H_W-1:1]));
    pos_s      = qs + half_s;
    upper      = (height_r == '0) ? '0 : height_r - 1'b1;
    upper_s    = $signed(POS_W'(upper));
    if (pos_s < 0) begin
      trace_c = '0;
    end else if (pos_s > upper_s) begin
      trace_c = upper;
    end else begin
      trace_c = pos_s[H_W-1:0];
    end
  end

  // Frame statistics and page arithmetic
  always_comb begin
    sq_hi      = sqr_prod[2*MAG_W-1:stwa_pkg::SQ_SHIFT];
    e_sum      = (E_W+1)'(energy_r) + (E_W+1)'(sq_hi);
    thresh     = E_W'(count_r) * E_W'(stwa_pkg::MIN_ENERGY + 1);
    hit        = (energy_r >= thresh);
    pacc_sum   = (PACC_W+1)'(pacc_r) + (PACC_W+1)'(peak_r);
    pacc_sat   = pacc_sum[PACC_W] ? '1 : pacc_sum[PACC_W-1:0];
    frames_inc = frames_r + 1'b1;
    page_full  = (frames_inc >= FR_W'(AGC_FRAMES));
    page       = div_quot[PAGE_W-1:0];
    total_calc = (TOT_W+1)'(total_r) - (TOT_W+1)'(ring_rdata) + (TOT_W+1)'(page);
    total_new  = total_calc[TOT_W-1:0];
  end

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    height_nxt    = height_r;
    stereo_nxt    = stereo_r;
    eight_nxt     = eight_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    last_nxt      = last_r;
    quot_nxt      = quot_r;
    energy_nxt    = energy_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    pacc_nxt      = pacc_r;
    frames_nxt    = frames_r;
    total_nxt     = total_r;
    head_nxt      = head_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_trace_nxt = out_trace_r;
    out_last_nxt  = out_last_r;
    div_req       = '{start: 1'b0, steps: '0};
    div_dividend  = '0;
    div_divisor   = '0;
    sqr_start     = 1'b0;
    ring_we       = 1'b0;
    ring_wdata    = page;

    // Configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        stwa_pkg::CFG_HEIGHT:    height_nxt = cfg_data;
        stwa_pkg::CFG_STEREO:    stereo_nxt = cfg_data[0];
        stwa_pkg::CFG_EIGHT_BIT: eight_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt      = sum_c[SUM_W-1];
          mag_nxt      = mag_c;
          last_nxt     = in_tlast;
          sqr_start    = 1'b1;
          div_req      = '{start: 1'b1, steps: SW'(AVG_W)};
          div_dividend = DIV_W'(avg_r) << (DIV_W - AVG_W);
          div_divisor  = target_eff;
          state_nxt    = S_SCALE;
        end
      end
      S_SCALE: begin
        if (div_sts.done) begin
          div_req      = '{start: 1'b1, steps: SW'(MAG_W)};
          div_dividend = DIV_W'(mag_r) << (DIV_W - MAG_W);
          div_divisor  = scale_eff;
          state_nxt    = S_QUOT;
        end
      end
      S_QUOT: begin
        if (div_sts.done) begin
          quot_nxt  = div_quot[MAG_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_trace_nxt = trace_c;
          out_last_nxt  = last_r;
          energy_nxt    = e_sum[E_W] ? '1 : e_sum[E_W-1:0];
          peak_nxt      = (mag_r > peak_r) ? mag_r : peak_r;
          if (count_r < CNT_W'(MAX_COLUMNS)) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = last_r ? S_MEAN : S_IDLE;
        end
      end
      S_MEAN: begin
        energy_nxt = '0;
        peak_nxt   = '0;
        count_nxt  = '0;
        state_nxt  = S_IDLE;
        if (hit) begin
          pacc_nxt   = pacc_sat;
          frames_nxt = frames_inc;
          if (page_full) begin
            div_req      = '{start: 1'b1, steps: SW'(PACC_W)};
            div_dividend = DIV_W'(pacc_sat) << (DIV_W - PACC_W);
            div_divisor  = PAGE_W'(AGC_FRAMES);
            state_nxt    = S_PAGE;
          end
        end
      end
      S_PAGE: begin
        if (div_sts.done) begin
          ring_we      = 1'b1;
          total_nxt    = total_new;
          head_nxt     = (head_r == HEAD_W'(AGC_PAGES - 1)) ? '0 : head_r + 1'b1;
          pacc_nxt     = '0;
          frames_nxt   = '0;
          div_req      = '{start: 1'b1, steps: SW'(TOT_W)};
          div_dividend = DIV_W'(total_new) << (DIV_W - TOT_W);
          div_divisor  = PAGE_W'(AGC_PAGES);
          state_nxt    = S_AVG;
        end
      end
      S_AVG: begin
        if (div_sts.done) begin
          avg_nxt   = div_quot[AVG_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, configuration, AGC state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      height_r    <= H_W'(stwa_pkg::HEIGHT_RESET);
      stereo_r    <= 1'b1;
      eight_r     <= 1'b0;
      energy_r    <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      pacc_r      <= '0;
      frames_r    <= '0;
      total_r     <= TOT_W'(stwa_pkg::PAGE_DEFAULT * AGC_PAGES);
      head_r      <= '0;
      avg_r       <= AVG_W'(stwa_pkg::PAGE_DEFAULT);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      height_r    <= height_nxt;
      stereo_r    <= stereo_nxt;
      eight_r     <= eight_nxt;
      energy_r    <= energy_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      pacc_r      <= pacc_nxt;
      frames_r    <= frames_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    last_r      <= last_nxt;
    quot_r      <= quot_nxt;
    out_trace_r <= out_trace_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Shared divider
  stwa_div #(
    .DW (DIV_W),
    .VW (PAGE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .sts      (div_sts)
  );

  // Energy squarer
  stwa_sqr u_sqr (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqr_start),
    .mag     (mag_c),
    .product (sqr_prod),
    .sts     (sqr_sts)
  );

  // Page ring
  stwa_ring #(
    .PAGES  (AGC_PAGES),
    .PAGE_W (PAGE_W)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (head_r),
    .we    (ring_we),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  assign out_tdata  = stwa_pkg::OUT_TDATA_W'(out_trace_r);
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

  // Squarer result is ready before the quotient lands
  a_sqr_before_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUOT && div_sts.done) |-> !sqr_sts.busy)
    else $error("squarer still busy when quotient completes");

  // Squarer finishes only during the two sample divisions
  a_sqr_done_window: assert property (@(posedge clk) disable iff (!rst_n)
    sqr_sts.done |-> (state_r == S_SCALE || state_r == S_QUOT))
    else $error("squarer finished outside the sample divisions");

  // A new column is taken only with the divider free
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !div_sts.busy)
    else $error("column accepted while divider busy");

  // Column count stays saturated within range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COLUMNS))
    else $error("column count beyond limit");

  // Frame and page counters stay in range; a full page waits for its division
  a_frames_range: assert property (@(posedge clk) disable iff (!rst_n)
    (frames_r <= FR_W'(AGC_FRAMES)) && (head_r <= HEAD_W'(AGC_PAGES - 1)))
    else $error("frame or ring counter out of range");

endmodule

// File: rtl/stwa_div.sv
// Restoring divider, one quotient bit per cycle, dividend given top-aligned.
module stwa_div #(
  parameter int DW = 21,
  parameter int VW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stwa_pkg::div_req_t   req,
  input  logic [DW-1:0]        dividend,
  input  logic [VW-1:0]        divisor,
  output logic [DW-1:0]        quotient,
  output stwa_pkg::unit_sts_t  sts
);

  logic [DW-1:0]                   num_r;
  logic [VW-1:0]                   rem_r;
  logic [VW-1:0]                   den_r;
  logic [stwa_pkg::DIV_STEP_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [VW:0]                     trial;
  logic [VW:0]                     diff;
  logic                            ge;

  // Trial subtraction for the next quotient bit
  always_comb begin
    trial = {rem_r, num_r[DW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == stwa_pkg::DIV_STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      num_r <= {num_r[DW-2:0], ge};
    end
  end

  assign quotient = num_r;
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

// File: rtl/stwa_sqr.sv
// Shift-and-add squarer, one multiplier bit per cycle.
module stwa_sqr (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [stwa_pkg::MAG_W-1:0]     mag,
  output logic [2*stwa_pkg::MAG_W-1:0]   product,
  output stwa_pkg::unit_sts_t            sts
);

  localparam int W   = stwa_pkg::MAG_W;
  localparam int CW  = $clog2(W + 1);

  logic [2*W-1:0] prod_r;
  logic [W-1:0]   mcand_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W:0]     part;

  // Add multiplicand into the upper half when the low bit is set
  always_comb begin
    part = {1'b0, prod_r[2*W-1:W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{W{1'b0}}, mag};
      mcand_r <= mag;
    end else if (busy_r) begin
      prod_r <= {part, prod_r[W-1:1]};
    end
  end

  assign product = prod_r;
  assign sts     = '{busy: busy_r, done: done_r};

endmodule

// File: rtl/stwa_ring.sv
// Page ring store with per-entry valid bits; empty entries read as the default page.
module stwa_ring #(
  parameter int PAGES  = 16,
  parameter int PAGE_W = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [$clog2(PAGES)-1:0]  addr,
  input  logic                      we,
  input  logic [PAGE_W-1:0]         wdata,
  output logic [PAGE_W-1:0]         rdata
);

  logic [PAGE_W-1:0] mem [PAGES];
  logic [PAGES-1:0]  valid_r;
  logic [PAGE_W-1:0] rdata_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[addr] <= 1'b1;
    end
  end

  // Storage, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= valid_r[addr] ? mem[addr] : PAGE_W'(stwa_pkg::PAGE_DEFAULT);
  end

  assign rdata = rdata_r;

endmodule
